@@ hw/rtl/itoa_pkg.sv @@
`default_nettype none

package itoa_pkg;

    // operand width; the value field carries 32 bits, so this stays at or below 32
    localparam int VALUE_BITS = 32;

    // operand padded to whole nibbles
    localparam int PAD_BITS   = ((VALUE_BITS + 3) / 4) * 4;
    localparam int HEX_DIGITS = PAD_BITS / 4;
    // decimal digit slots, enough for 2**VALUE_BITS - 1 (spare slots stay zero)
    localparam int DEC_DIGITS = (VALUE_BITS * 3) / 10 + 2;
    localparam int NDIG       = DEC_DIGITS;
    localparam int DIG_W      = NDIG * 4;
    localparam int CNT_W      = $clog2(NDIG + 1);
    localparam int STEP_W     = $clog2(HEX_DIGITS + 1);

    localparam int QUEUE_DEPTH_DEF = 2;

    // mode codes
    localparam logic [1:0] MODE_SDEC = 2'd0;
    localparam logic [1:0] MODE_UDEC = 2'd1;
    localparam logic [1:0] MODE_LHEX = 2'd2;
    localparam logic [1:0] MODE_UHEX = 2'd3;

    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } out_item_t;

    // classified operand as handed from front to back
    typedef struct packed {
        logic                  neg;
        logic                  hex;
        logic                  upper;
        logic [VALUE_BITS-1:0] mag;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } head_t;

    typedef struct packed {
        logic busy;
        logic emitting;
    } back_stat_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] res;
        if (d < 4'd10) begin
            res = CH_ZERO + {4'b0000, d};
        end
        else if (upper) begin
            res = CH_UPPER_A + {4'b0000, d - 4'd10};
        end
        else begin
            res = CH_LOWER_A + {4'b0000, d - 4'd10};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/itoa_front.sv @@
`default_nettype none

module itoa_front (
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire itoa_pkg::in_item_t item,
    input  wire logic              q_full,
    output itoa_pkg::push_t        push
);
    import itoa_pkg::*;

    logic [VALUE_BITS-1:0] v;
    logic                  neg;

    // negative signed operand: take two's complement magnitude
    assign v   = item.value[VALUE_BITS-1:0];
    assign neg = (item.mode == MODE_SDEC) && v[VALUE_BITS-1];

    assign item_stall    = q_full;
    assign push.valid    = item_valid && !q_full;
    assign push.job.neg  = neg;
    assign push.job.hex  = (item.mode == MODE_LHEX) || (item.mode == MODE_UHEX);
    assign push.job.upper = (item.mode == MODE_UHEX);
    assign push.job.mag  = neg ? VALUE_BITS'(~v + 1'b1) : v;

endmodule

`default_nettype wire

@@ hw/rtl/itoa_queue.sv @@
`default_nettype none

module itoa_queue #(
    parameter int DEPTH = itoa_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire itoa_pkg::push_t push,
    input  wire logic           pop,
    output logic                full,
    output itoa_pkg::head_t     head
);
    import itoa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push.valid && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push.valid)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/itoa_back.sv @@
`default_nettype none

module itoa_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire itoa_pkg::head_t head,
    output logic                 pop,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output itoa_pkg::out_item_t  result,
    output itoa_pkg::back_stat_t stat
);
    import itoa_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic [DIG_W-1:0]    dig_reg;
    logic [PAD_BITS-1:0] mag_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                neg_reg;
    logic                upper_reg;
    logic                out_valid_reg;
    out_item_t           out_reg;

    logic [PAD_BITS-1:0] load_mag;
    logic [DIG_W-1:0]    dabble_next;
    logic [3:0]          top_dig;
    logic                room;

    // one shift-and-add-3 step over every bcd slot
    function automatic logic [DIG_W-1:0] dabble(input logic [DIG_W-1:0] bcd, input logic b);
        logic [DIG_W-1:0] adj;
        adj = bcd;
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
            end
        end
        return {adj[DIG_W-2:0], b};
    endfunction

    always_comb
    begin
        dabble_next = dig_reg;
        for (int k = 0; k < 4; k++)
        begin
            dabble_next = dabble(dabble_next, mag_reg[PAD_BITS-1-k]);
        end
    end

    assign load_mag = PAD_BITS'(head.job.mag);
    assign top_dig  = dig_reg[DIG_W-1 -: 4];
    assign room     = !out_valid_reg || !result_stall;
    assign pop      = (state_reg == ST_IDLE) && head.valid;

    assign result_valid  = out_valid_reg;
    assign result        = out_reg;
    assign stat.busy     = (state_reg != ST_IDLE);
    assign stat.emitting = (state_reg == ST_EMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dig_reg       <= '0;
            mag_reg       <= '0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            neg_reg       <= 1'b0;
            upper_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            // in emit the output valid is handled by the emit arm
            if (out_valid_reg && !result_stall && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (head.valid)
                    begin
                        neg_reg   <= head.job.neg;
                        upper_reg <= head.job.upper;
                        if (head.job.hex)
                        begin
                            dig_reg   <= DIG_W'(load_mag) << (DIG_W - PAD_BITS);
                            cnt_reg   <= CNT_W'(HEX_DIGITS);
                            state_reg <= ST_SKIP;
                        end
                        else
                        begin
                            dig_reg   <= '0;
                            mag_reg   <= load_mag;
                            step_reg  <= STEP_W'(HEX_DIGITS);
                            state_reg <= ST_CONV;
                        end
                    end
                end
                ST_CONV:
                begin
                    dig_reg  <= dabble_next;
                    mag_reg  <= mag_reg << 4;
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == STEP_W'(1))
                    begin
                        cnt_reg   <= CNT_W'(NDIG);
                        state_reg <= ST_SKIP;
                    end
                end
                ST_SKIP:
                begin
                    // drop leading zeros, keep at least one digit
                    if ((top_dig == 4'd0) && (cnt_reg != CNT_W'(1)))
                    begin
                        dig_reg <= dig_reg << 4;
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (room)
                    begin
                        out_valid_reg <= 1'b1;
                        if (neg_reg)
                        begin
                            out_reg.char_out <= CH_MINUS;
                            out_reg.last     <= 1'b0;
                            neg_reg          <= 1'b0;
                        end
                        else
                        begin
                            out_reg.char_out <= digit_char(top_dig, upper_reg);
                            out_reg.last     <= (cnt_reg == CNT_W'(1));
                            dig_reg          <= dig_reg << 4;
                            cnt_reg          <= cnt_reg - 1'b1;
                            if (cnt_reg == CNT_W'(1))
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/integer_to_ascii_dec_hex.sv @@
// path: hex operands go from the queue through leading-zero skip to the character output;
//   decimal operands first pass the nibble-serial bcd unit, then leading-zero skip and output
// throughput: one character per cycle once emitting, while result_stall is low; the back end
//   takes the next operand only after the last character of the current one
// reset: rst_n asynchronous, active low; clears queue, state and output valid
`default_nettype none

module integer_to_ascii_dec_hex #(
    parameter int QUEUE_DEPTH = itoa_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire itoa_pkg::in_item_t item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output itoa_pkg::out_item_t     result
);
    import itoa_pkg::*;

    // front to queue: classified operand (sign, base, letter case, magnitude)
    push_t      push;
    logic       q_full;
    // queue to back: oldest classified operand
    head_t      head;
    logic       pop;
    back_stat_t bk_stat;

    // front: sign check and negation, base and case decode
    itoa_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .push       (push)
    );

    // short queue decouples accepting operands from emitting characters
    itoa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    // back: bcd conversion four bits a cycle, leading zero skip, character output register
    itoa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .stat         (bk_stat)
    );

    // a minus sign always has digits after it
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.char_out == CH_MINUS)) |-> !result.last)
        else $error("minus sign flagged as last");

    // only digits, hex letters or minus leave the block
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.char_out >= 8'h30 && result.char_out <= 8'h39) ||
                          (result.char_out >= 8'h61 && result.char_out <= 8'h66) ||
                          (result.char_out >= 8'h41 && result.char_out <= 8'h46) ||
                          (result.char_out == CH_MINUS)))
        else $error("unexpected character");

    // a new character is loaded only while the back end is emitting
    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        !bk_stat.emitting |=> !$rose(result_valid))
        else $error("character produced outside emit");

    // the back end never takes an operand while the queue is empty
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ tb/sv/integer_to_ascii_dec_hex_checker.sv @@
module itoa_char_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_stall,
    input  itoa_pkg::in_item_t  item,
    input  logic                result_valid,
    input  logic                result_stall,
    input  itoa_pkg::out_item_t result,
    output int                  fail_count,
    output int                  pending
);
    import itoa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // characters still owed by the block, oldest first
    out_item_t expected_chars[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // spell one operand out in its mode and queue the characters
    function automatic void predict_chars(input in_item_t op);
        logic [31:0] mag;
        logic [31:0] radix;
        logic [3:0]  d;
        logic        neg;
        logic [7:0]  spelled[$];
        out_item_t   ch;
        neg   = (op.mode == MODE_SDEC) && op.value[31];
        mag   = neg ? (~op.value + 32'd1) : op.value;
        radix = (op.mode == MODE_LHEX || op.mode == MODE_UHEX) ? 32'd16 : 32'd10;
        if (neg)
        begin
            ch.char_out = CH_MINUS;
            ch.last     = 1'b0;
            expected_chars.push_back(ch);
        end
        do
        begin
            d = 4'(mag % radix);
            if (d < 4'd10)
                spelled.push_front(CH_ZERO + {4'b0000, d});
            else if (op.mode == MODE_UHEX)
                spelled.push_front(CH_UPPER_A + {4'b0000, d} - 8'd10);
            else
                spelled.push_front(CH_LOWER_A + {4'b0000, d} - 8'd10);
            mag = mag / radix;
        end
        while (mag != 32'd0);
        foreach (spelled[i])
        begin
            ch.char_out = spelled[i];
            ch.last     = (i == spelled.size() - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    always @(posedge clk)
    begin : watch
        out_item_t want;
        if (rst_n)
        begin
            // results first: a char leaving now never belongs to an item taken now
            if (result_valid && !result_stall)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch($sformatf("char %h with nothing expected", result.char_out));
                else
                begin
                    want = expected_chars.pop_front();
                    if (result.char_out !== want.char_out)
                        report_mismatch($sformatf("char_out %h, expected %h",
                                                  result.char_out, want.char_out));
                    if (result.last !== want.last)
                        report_mismatch($sformatf("last %b on char %h, expected %b",
                                                  result.last, want.char_out, want.last));
                end
            end
            if (item_valid && !item_stall)
                predict_chars(item);
            pending = expected_chars.size();
        end
    end

endmodule

@@ tb/sv/integer_to_ascii_dec_hex_tb.sv @@
module integer_to_ascii_dec_hex_tb;
    import itoa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no item moving on either side before the run is called hung
    localparam int IDLE_LIMIT   = 2000;
    // long receiver hold-off that lets the block fill up and stall its input
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AFTER   = 60;
    localparam int RANDOM_ITEMS = 430;
    // back end worst case: setup, bcd conversion, skipped zeros and 11 chars
    localparam int DRAIN_CYCLES = 40;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;

    int fail_count;
    int pending;
    int items_sent;
    int burst_left;
    int idle_cycles;
    bit hold_done;

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    integer_to_ascii_dec_hex i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // prediction and comparison live beside the block
    itoa_char_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // offer one item, called at a falling edge; returns at the falling edge after it
    // was taken. bursts of random length with random gaps in front of them
    task automatic send_item(input logic [1:0] m, input logic [31:0] v);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            // a quarter of the bursts follow straight on for stretches with no idling
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= '{mode: m, value: v};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // operand mix: decade and nibble boundaries, short numbers and the sign edge,
    // next to plain random words so every bit sees both values
    function automatic logic [31:0] pick_value();
        logic [31:0] p;
        int          n;
        p = 32'd1;
        case ($urandom_range(0, 6))
            0, 1:    return $urandom();
            2:       return $urandom_range(0, 20);
            3:
            begin
                n = $urandom_range(0, 9);
                repeat (n) p = p * 32'd10;
                return p + $urandom_range(0, 2) - 32'd1;
            end
            4:
            begin
                p = 32'd1 << (4 * $urandom_range(0, 7));
                return p + $urandom_range(0, 2) - 32'd1;
            end
            5:       return 32'h8000_0000 + $urandom_range(0, 4) - 32'd2;
            default: return $urandom() >> $urandom_range(1, 31);
        endcase
    endfunction

    // receiver: stall style changes every segment, with one long hold-off once
    // the sender has pushed enough items to keep the block full
    initial
    begin : receiver
        int style;
        int seg_len;
        result_stall <= 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            style   = $urandom_range(0, 3);
            seg_len = $urandom_range(20, 120);
            repeat (seg_len)
            begin
                @(negedge clk);
                if (!hold_done && items_sent >= HOLD_AFTER)
                begin
                    hold_done = 1'b1;
                    result_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                case (style)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    2:       result_stall <= ($urandom_range(0, 9) < 7);
                    default: result_stall <= ~result_stall;
                endcase
            end
        end
    end

    // watchdog: any cycle moving an item on either side restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("integer_to_ascii_dec_hex test failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        items_sent  = 0;
        burst_left  = 0;
        idle_cycles = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero in every mode
        send_item(MODE_SDEC, 32'h0000_0000);
        send_item(MODE_UDEC, 32'h0000_0000);
        send_item(MODE_LHEX, 32'h0000_0000);
        send_item(MODE_UHEX, 32'h0000_0000);
        // most negative signed value and its unsigned / hex readings
        send_item(MODE_SDEC, 32'h8000_0000);
        send_item(MODE_UDEC, 32'h8000_0000);
        send_item(MODE_LHEX, 32'h8000_0000);
        // all ones: -1, the longest unsigned number, eight hex f's
        send_item(MODE_SDEC, 32'hFFFF_FFFF);
        send_item(MODE_UDEC, 32'hFFFF_FFFF);
        send_item(MODE_LHEX, 32'hFFFF_FFFF);
        send_item(MODE_UHEX, 32'hFFFF_FFFF);
        // largest positive signed, single digits and decade edges
        send_item(MODE_SDEC, 32'h7FFF_FFFF);
        send_item(MODE_SDEC, 32'h0000_0001);
        send_item(MODE_UDEC, 32'd9);
        send_item(MODE_UDEC, 32'd10);
        send_item(MODE_UDEC, 32'd999_999_999);
        send_item(MODE_UDEC, 32'd1_000_000_000);
        send_item(MODE_SDEC, 32'hC465_3600);
        // letters in both cases, nibble edges
        send_item(MODE_LHEX, 32'hDEAD_BEEF);
        send_item(MODE_UHEX, 32'hABCD_EF09);
        send_item(MODE_LHEX, 32'h0000_000F);
        send_item(MODE_UHEX, 32'h0000_0010);

        repeat (RANDOM_ITEMS)
            send_item(2'($urandom_range(0, 3)), pick_value());
        item_valid <= 1'b0;

        // drain every owed char, then give the back end time to show anything extra
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("integer_to_ascii_dec_hex test passed");
        else
            $display("integer_to_ascii_dec_hex test failed");
        $finish;
    end

endmodule
